/* hdl/tvfs_pkg.sv */
// Shared types and constants for the tag/value field splitter.
`default_nettype none
package tvfs_pkg;

  localparam logic [7:0] DelimReset = 8'h7C;
  localparam logic [7:0] CharEq     = 8'h3D;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharCr     = 8'h0D;

  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);

  localparam logic KindValue = 1'b0;
  localparam logic KindEnd   = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] tag_num;
    logic               tag_valid;
    logic [7:0]         value_byte;
    logic               message_done;
    logic               last_of_run;
  } out_beat_t;

  // one byte's work, handed from the parser to the emitter
  typedef struct packed {
    logic        has_val;
    logic        has_rec;
    logic [7:0]  value_byte;
    logic [31:0] mag;
    logic        neg;
    logic        valid;
    logic        done;
  } cmd_t;

endpackage
`default_nettype wire

/* hdl/tvfs_front.sv */
// Parser front end: delimiter register, tag conversion and field state.
`default_nettype none
module tvfs_front import tvfs_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     acc_i,
  input  wire in_beat_t in_beat_i,
  input  wire logic     cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  output logic          cmd_we_o,
  output cmd_t          cmd_o
);

  typedef enum logic [6:0] {
    PhStart  = 7'b0000001,
    PhWs     = 7'b0000010,
    PhSign   = 7'b0000100,
    PhDigits = 7'b0001000,
    PhJunk   = 7'b0010000,
    PhValue  = 7'b0100000,
    PhDrop   = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic        seen_q, seen_d;
  logic        ovf_q, ovf_d;
  logic [7:0]  delim_q;

  logic [7:0]  c;
  logic        eom;
  logic        is_digit, is_space, do_digit, close_req;
  logic [35:0] prod, limit;
  cmd_t        cmd;

  assign c   = in_beat_i.data_byte;
  assign eom = in_beat_i.end_of_message;

  always_comb begin
    is_digit = (c >= CharZero) && (c <= CharNine);
    is_space = c inside {CharSpace, [CharTab:CharCr]};
    prod  = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {32'd0, c[3:0]};
    limit = neg_q ? 36'h080000000 : 36'h07FFFFFFF;
  end

  always_comb begin
    phase_d   = phase_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    seen_d    = seen_q;
    ovf_d     = ovf_q;
    do_digit  = 1'b0;
    close_req = 1'b0;
    cmd       = '0;
    cmd.value_byte = c;

    if (c == delim_q) begin
      close_req = 1'b1;
      cmd.done  = eom;
    end else begin
      if (phase_q == PhStart && c == CharEq) begin
        phase_d = PhDrop;
      end else if (phase_q == PhValue) begin
        cmd.has_val = seen_q & ~ovf_q;
      end else if (phase_q != PhDrop) begin
        if (c == CharEq) begin
          phase_d = PhValue;
        end else begin
          case (phase_q)
            PhStart, PhWs: begin
              if (is_space) begin
                phase_d = PhWs;
              end else if (c == CharPlus || c == CharMinus) begin
                neg_d   = (c == CharMinus);
                phase_d = PhSign;
              end else if (is_digit) begin
                do_digit = 1'b1;
              end else begin
                phase_d = PhJunk;
              end
            end
            PhSign, PhDigits: begin
              if (is_digit) begin
                do_digit = 1'b1;
              end else begin
                phase_d = PhJunk;
              end
            end
            default: ;
          endcase
        end
      end
      close_req = eom;
      cmd.done  = eom;
    end

    if (do_digit) begin
      seen_d  = 1'b1;
      phase_d = PhDigits;
      if (!ovf_q) begin
        if (prod > limit) begin
          ovf_d = 1'b1;
        end else begin
          mag_d = prod[31:0];
        end
      end
    end

    cmd.mag   = mag_d;
    cmd.neg   = neg_d;
    cmd.valid = seen_d & ~ovf_d;

    if (close_req) begin
      cmd.has_rec = (phase_d != PhStart) && (phase_d != PhDrop);
      phase_d = PhStart;
      mag_d   = '0;
      neg_d   = 1'b0;
      seen_d  = 1'b0;
      ovf_d   = 1'b0;
    end
  end

  assign cmd_o    = cmd;
  assign cmd_we_o = acc_i & (cmd.has_val | cmd.has_rec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      ovf_q   <= 1'b0;
      delim_q <= DelimReset;
    end else begin
      if (acc_i) begin
        phase_q <= phase_d;
        mag_q   <= mag_d;
        neg_q   <= neg_d;
        seen_q  <= seen_d;
        ovf_q   <= ovf_d;
      end
      if (cfg_we_i) begin
        delim_q <= cfg_data_i;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/tvfs_cmd_fifo.sv */
// Short command queue between parser and emitter.
`default_nettype none
module tvfs_cmd_fifo import tvfs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  wire cmd_t wr_data_i,
  input  wire logic rd_i,
  output cmd_t      rd_data_o,
  output logic      full_o,
  output logic      empty_o
);

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdPtrW:0]   count_q;

  assign full_o    = (count_q == (CmdPtrW + 1)'(CmdDepth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == CmdPtrW'(CmdDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({wr_i, rd_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/tvfs_back.sv */
// Emitter back end: expands each command into value and end-of-field beats.
`default_nettype none
module tvfs_back import tvfs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cmd_t head_i,
  input  wire logic head_valid_i,
  output logic      head_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output out_beat_t out_o
);

  out_beat_t out_q, rec_q;
  logic      out_valid_q, rec_pend_q;
  logic      load;
  logic signed [31:0] tag;
  out_beat_t val_beat, rec_beat;

  always_comb begin
    tag = '0;
    if (head_i.valid) begin
      tag = head_i.neg ? $signed(32'(-head_i.mag)) : $signed(head_i.mag);
    end
    val_beat.kind         = KindValue;
    val_beat.tag_num      = tag;
    val_beat.tag_valid    = head_i.valid;
    val_beat.value_byte   = head_i.value_byte;
    val_beat.message_done = 1'b0;
    val_beat.last_of_run  = ~head_i.has_rec;
    rec_beat.kind         = KindEnd;
    rec_beat.tag_num      = tag;
    rec_beat.tag_valid    = head_i.valid;
    rec_beat.value_byte   = '0;
    rec_beat.message_done = head_i.done;
    rec_beat.last_of_run  = 1'b1;
  end

  assign load       = ~out_valid_q | pop_i;
  assign head_pop_o = load & ~rec_pend_q & head_valid_i;
  assign empty_o    = ~out_valid_q;
  assign out_o      = out_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (rec_pend_q) begin
        out_q <= rec_q;
      end else if (head_valid_i) begin
        out_q <= head_i.has_val ? val_beat : rec_beat;
        rec_q <= rec_beat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rec_pend_q  <= 1'b0;
    end else if (load) begin
      if (rec_pend_q) begin
        out_valid_q <= 1'b1;
        rec_pend_q  <= 1'b0;
      end else begin
        out_valid_q <= head_valid_i;
        rec_pend_q  <= head_valid_i & head_i.has_val & head_i.has_rec;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/tag_value_field_splitter_top.sv */
// Top level of the tag/value field splitter.
//
//   channel  direction  handshake               beat
//   input    in         push / full             in_data_i  (in_beat_t)
//   result   out        empty / pop             out_data_o (out_beat_t)
//   config   in         cfg_valid_i/cfg_ready_o cfg_data_i (delimiter)
//
// One byte accepted per cycle while full is low; up to two result beats per byte, one per cycle while popped.
// A parsed byte's command passes through the command queue, then the output register, to the result.
// Result stalls back up through a 4-entry command queue before full rises.
// Reset clears field state and sets the delimiter to '|'.
`default_nettype none
module tag_value_field_splitter_top import tvfs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire in_beat_t   in_data_i,
  output logic            empty,
  input  wire logic       pop,
  output out_beat_t       out_data_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  logic acc, cmd_we, cmd_full, cmd_empty, cmd_rd;
  cmd_t cmd_wr, cmd_head;

  assign acc         = push & ~cmd_full;
  assign full        = cmd_full;
  assign cfg_ready_o = 1'b1;

  tvfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .in_beat_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_we_o   (cmd_we),
    .cmd_o      (cmd_wr)
  );

  tvfs_cmd_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cmd_we),
    .wr_data_i (cmd_wr),
    .rd_i      (cmd_rd),
    .rd_data_o (cmd_head),
    .full_o    (cmd_full),
    .empty_o   (cmd_empty)
  );

  tvfs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (cmd_head),
    .head_valid_i (~cmd_empty),
    .head_pop_o   (cmd_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_o        (out_data_o)
  );

endmodule
`default_nettype wire

/* hdl/tvfs_checker.sv */
// Port-level checks for the tag/value field splitter, bound to the top level.
`default_nettype none
module tvfs_checker import tvfs_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      empty,
  input wire logic      pop,
  input wire out_beat_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_data_o)))
    else $error("result beat changed while stalled");

  a_value_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.kind == KindValue) |->
      (out_data_o.tag_valid && !out_data_o.message_done))
    else $error("value beat with invalid tag or message_done");

  a_end_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_data_o.kind == KindEnd) |->
      (out_data_o.value_byte == 8'd0 && out_data_o.last_of_run))
    else $error("end-of-field beat malformed");

  a_bad_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_data_o.tag_valid) |-> (out_data_o.tag_num == 32'sd0))
    else $error("invalid tag with nonzero number");

endmodule

bind tag_value_field_splitter_top tvfs_checker u_tvfs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_data_o (out_data_o)
);
`default_nettype wire
